// File: src/mcmf_pkg.sv
// ----------------------------------------------------------------------------
// Min-cut / max-flow package
// Shared widths, codes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package mcmf_pkg;

  localparam int NODE_W        = 5;
  localparam int MAT_W         = 26;
  localparam int RES_W         = MAT_W + 1;
  localparam int CNT_W         = 7;
  localparam int MAX_RESULTS   = 64;
  localparam int NODE_RESET    = 16;
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_MAX_EDGES = 1024;
  localparam int DEF_CAP_WIDTH = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic load_add;
    logic add_rd;
    logic add_w1;
    logic add_w2;
    logic copy_rd;
    logic bfs_init;
    logic bfs_pop;
    logic bfs_rd;
    logic aug_init;
    logic aug_rd;
    logic aug_min;
    logic sub_rd;
    logic sub_w1;
    logic sub_w2;
    logic cut_init;
    logic cut_rd;
    logic sel_rd;
    logic emit_load;
    logic empty_load;
    logic finish;
  } mcmf_cmd_t;

  typedef struct packed {
    logic add_ok;
    logic k_last;
    logic i_last;
    logic q_empty;
    logic sink_hit;
    logic par_zero;
    logic cut_none;
    logic out_free;
    logic emit_last;
  } mcmf_stat_t;

endpackage

// File: src/mcmf_ctrl.sv
// ----------------------------------------------------------------------------
// Min-cut / max-flow controller
// Sequences edge loads, the residual copy, the breadth-first search, path
// augmentation, the cut sweep and the ordered emission of cut edges.
// ----------------------------------------------------------------------------
module mcmf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  op,
  input  mcmf_pkg::mcmf_stat_t  stat,
  output mcmf_pkg::mcmf_cmd_t   cmd,
  output logic                  in_stall
);
  import mcmf_pkg::*;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_ADD_RD     = 5'd1;
  localparam logic [4:0] S_ADD_W1     = 5'd2;
  localparam logic [4:0] S_ADD_W2     = 5'd3;
  localparam logic [4:0] S_COPY       = 5'd4;
  localparam logic [4:0] S_COPY_DRAIN = 5'd5;
  localparam logic [4:0] S_BFS_INIT   = 5'd6;
  localparam logic [4:0] S_BFS_POP    = 5'd7;
  localparam logic [4:0] S_BFS_SCAN   = 5'd8;
  localparam logic [4:0] S_BFS_DRAIN  = 5'd9;
  localparam logic [4:0] S_AUG_RD     = 5'd10;
  localparam logic [4:0] S_AUG_MIN    = 5'd11;
  localparam logic [4:0] S_SUB_RD     = 5'd12;
  localparam logic [4:0] S_SUB_W1     = 5'd13;
  localparam logic [4:0] S_SUB_W2     = 5'd14;
  localparam logic [4:0] S_CUT        = 5'd15;
  localparam logic [4:0] S_CUT_DRAIN  = 5'd16;
  localparam logic [4:0] S_CUT_DONE   = 5'd17;
  localparam logic [4:0] S_SEL        = 5'd18;
  localparam logic [4:0] S_SEL_DRAIN  = 5'd19;
  localparam logic [4:0] S_EMIT       = 5'd20;
  localparam logic [4:0] S_EMPTY      = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_ADD) begin
            cmd.load_add = 1'b1;
            state_next   = S_ADD_RD;
          end else begin
            state_next = S_COPY;
          end
        end
      end
      S_ADD_RD: begin
        if (stat.add_ok) begin
          cmd.add_rd = 1'b1;
          state_next = S_ADD_W1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ADD_W1: begin
        cmd.add_w1 = 1'b1;
        state_next = S_ADD_W2;
      end
      S_ADD_W2: begin
        cmd.add_w2 = 1'b1;
        state_next = S_IDLE;
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (stat.k_last) state_next = S_COPY_DRAIN;
      end
      S_COPY_DRAIN: begin
        state_next = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        cmd.bfs_init = 1'b1;
        state_next   = S_BFS_POP;
      end
      S_BFS_POP: begin
        if (stat.sink_hit) begin
          cmd.aug_init = 1'b1;
          state_next   = S_AUG_RD;
        end else if (stat.q_empty) begin
          cmd.cut_init = 1'b1;
          state_next   = S_CUT;
        end else begin
          cmd.bfs_pop = 1'b1;
          state_next  = S_BFS_SCAN;
        end
      end
      S_BFS_SCAN: begin
        cmd.bfs_rd = 1'b1;
        if (stat.i_last) state_next = S_BFS_DRAIN;
      end
      S_BFS_DRAIN: begin
        state_next = S_BFS_POP;
      end
      S_AUG_RD: begin
        cmd.aug_rd = 1'b1;
        state_next = S_AUG_MIN;
      end
      S_AUG_MIN: begin
        cmd.aug_min = 1'b1;
        state_next  = stat.par_zero ? S_SUB_RD : S_AUG_RD;
      end
      S_SUB_RD: begin
        cmd.sub_rd = 1'b1;
        state_next = S_SUB_W1;
      end
      S_SUB_W1: begin
        cmd.sub_w1 = 1'b1;
        state_next = S_SUB_W2;
      end
      S_SUB_W2: begin
        cmd.sub_w2 = 1'b1;
        state_next = stat.par_zero ? S_BFS_INIT : S_SUB_RD;
      end
      S_CUT: begin
        cmd.cut_rd = 1'b1;
        if (stat.k_last) state_next = S_CUT_DRAIN;
      end
      S_CUT_DRAIN: begin
        state_next = S_CUT_DONE;
      end
      S_CUT_DONE: begin
        state_next = stat.cut_none ? S_EMPTY : S_SEL;
      end
      S_SEL: begin
        cmd.sel_rd = 1'b1;
        if (stat.k_last) state_next = S_SEL_DRAIN;
      end
      S_SEL_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_SEL;
          end
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_load = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/mcmf_dpath.sv
// ----------------------------------------------------------------------------
// Min-cut / max-flow datapath
// Capacity, edge-number and residual memories, the search queue and parent
// table, path augmentation, the cut accumulator and the result register.
// ----------------------------------------------------------------------------
module mcmf_dpath #(
  parameter int MAX_NODES = mcmf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = mcmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_WIDTH = mcmf_pkg::DEF_CAP_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mcmf_pkg::NODE_W-1:0]        from_node,
  input  logic [mcmf_pkg::NODE_W-1:0]        to_node,
  input  logic [CAP_WIDTH-1:0]               edge_capacity,
  input  logic                               cfg_valid,
  input  logic [mcmf_pkg::NODE_W-1:0]        node_count,
  input  mcmf_pkg::mcmf_cmd_t                cmd,
  output mcmf_pkg::mcmf_stat_t               stat,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [mcmf_pkg::CNT_W-1:0]         cut_count,
  output logic [mcmf_pkg::MAT_W-1:0]         cut_sum,
  output logic                               edge_valid,
  output logic [$clog2(MAX_EDGES+1)-1:0]     edge_number,
  output logic                               last
);
  import mcmf_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int NN    = 1 << NW;
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int QW    = NW + 1;
  localparam int TW    = AW + 1;
  localparam int SAT_W = (CAP_WIDTH > MAT_W ? CAP_WIDTH : MAT_W) + 1;
  localparam int SUM_X = MAT_W + 1;
  localparam int N_RST = NODE_RESET > MAX_NODES ? MAX_NODES : NODE_RESET;
  localparam logic [MAT_W-1:0] MAT_MAX = '1;

  // Configuration
  logic [NODE_W-1:0] n_reg;
  logic [NW-1:0]     sink;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg <= NODE_W'(N_RST);
    end else if (cfg_valid) begin
      if (node_count < NODE_W'(2)) begin
        n_reg <= NODE_W'(2);
      end else if (int'(node_count) > MAX_NODES) begin
        n_reg <= NODE_W'(MAX_NODES);
      end else begin
        n_reg <= node_count;
      end
    end
  end

  assign sink = NW'(n_reg - NODE_W'(1));

  // Edge request latch and arrival numbering
  logic [EW-1:0]        edges;
  logic [EW-1:0]        num_r;
  logic [NW-1:0]        a_r;
  logic [NW-1:0]        b_r;
  logic [CAP_WIDTH-1:0] c_r;
  logic                 add_ok;
  logic                 ep_ok;
  logic                 room;

  assign ep_ok = (from_node != '0) && (from_node <= n_reg) &&
                 (to_node != '0) && (to_node <= n_reg);
  assign room  = int'(edges) < MAX_EDGES;

  always_ff @(posedge clk) begin
    if (rst) begin
      edges  <= '0;
      add_ok <= 1'b0;
    end else if (cmd.finish) begin
      edges <= '0;
    end else if (cmd.load_add) begin
      add_ok <= room && ep_ok;
      if (room) edges <= edges + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_add) begin
      num_r <= edges + EW'(1);
      a_r   <= NW'(from_node - NODE_W'(1));
      b_r   <= NW'(to_node - NODE_W'(1));
      c_r   <= edge_capacity;
    end
  end

  // Sweep counter over all matrix entries
  logic [AW-1:0] k;
  logic [AW-1:0] k_d;
  logic          copy_p;
  logic          cut_p;
  logic          sel_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      copy_p <= 1'b0;
      cut_p  <= 1'b0;
      sel_p  <= 1'b0;
    end else begin
      if (cmd.copy_rd || cmd.cut_rd || cmd.sel_rd) k <= k + AW'(1);
      copy_p <= cmd.copy_rd;
      cut_p  <= cmd.cut_rd;
      sel_p  <= cmd.sel_rd;
    end
  end

  always_ff @(posedge clk) begin
    k_d <= k;
  end

  // Capacity and edge-number memories; capacities without a valid bit read as zero
  logic [MAT_W-1:0] cap_mem [DEPTH];
  logic [EW-1:0]    num_mem [DEPTH];
  logic [DEPTH-1:0] cap_vld;
  logic [MAT_W-1:0] cap_rd;
  logic [EW-1:0]    num_rd;
  logic             vld_rd;
  logic [MAT_W-1:0] cap_eff;
  logic             cap_re;
  logic [AW-1:0]    cap_ra;
  logic             cap_we;
  logic [AW-1:0]    cap_wa;
  logic [MAT_W-1:0] cap_wd;
  logic [SAT_W-1:0] cap_sum;

  assign cap_eff = vld_rd ? cap_rd : '0;
  assign cap_re  = cmd.add_rd || cmd.add_w1 || cmd.copy_rd || cmd.cut_rd || cmd.sel_rd;
  assign cap_ra  = cmd.add_rd ? {a_r, b_r} : (cmd.add_w1 ? {b_r, a_r} : k);
  assign cap_we  = cmd.add_w1 || cmd.add_w2;
  assign cap_wa  = cmd.add_w1 ? {a_r, b_r} : {b_r, a_r};
  assign cap_sum = SAT_W'(cap_eff) + SAT_W'(c_r);
  assign cap_wd  = (cap_sum > SAT_W'(MAT_MAX)) ? MAT_MAX : cap_sum[MAT_W-1:0];

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_wa] <= cap_wd;
      num_mem[cap_wa] <= num_r;
    end
    if (cap_re) begin
      cap_rd <= cap_mem[cap_ra];
      num_rd <= num_mem[cap_ra];
      vld_rd <= cap_vld[cap_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      cap_vld <= '0;
    end else if (cap_we) begin
      cap_vld[cap_wa] <= 1'b1;
    end
  end

  // Search state
  logic [NN-1:0] reach;
  logic [NW-1:0] parent [NN];
  logic [NW-1:0] queue [NN];
  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [NW-1:0] v_r;
  logic [NW-1:0] i_r;
  logic [NW-1:0] i_d;
  logic          bfs_p;
  logic          hit;

  // Residual memory with two read ports
  logic [RES_W-1:0] res_mem [DEPTH];
  logic [RES_W-1:0] res_rd_a;
  logic [RES_W-1:0] res_rd_b;
  logic             res_we;
  logic [AW-1:0]    res_wa;
  logic [RES_W-1:0] res_wd;
  logic             res_rea;
  logic [AW-1:0]    res_raa;
  logic [NW-1:0]    cur;
  logic [NW-1:0]    par_r;
  logic [NW-1:0]    par_cur;
  logic [RES_W-1:0] flow;

  assign par_cur = parent[cur];
  assign hit     = bfs_p && (res_rd_a != '0) && !reach[i_d];
  assign res_rea = cmd.bfs_rd || cmd.aug_rd || cmd.sub_rd;
  assign res_raa = cmd.bfs_rd ? {v_r, i_r} : {par_cur, cur};

  always_comb begin
    res_we = 1'b0;
    res_wa = k_d;
    res_wd = RES_W'(cap_eff);
    if (copy_p) begin
      res_we = 1'b1;
    end else if (cmd.sub_w1) begin
      res_we = 1'b1;
      res_wa = {par_r, cur};
      res_wd = res_rd_a - flow;
    end else if (cmd.sub_w2) begin
      res_we = 1'b1;
      res_wa = {cur, par_r};
      res_wd = res_rd_b + flow;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    if (res_rea) res_rd_a <= res_mem[res_raa];
    if (cmd.sub_rd) res_rd_b <= res_mem[{cur, par_cur}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      bfs_p <= 1'b0;
    end else begin
      bfs_p <= cmd.bfs_rd;
      if (cmd.bfs_init) begin
        head <= '0;
        tail <= QW'(1);
      end else begin
        if (cmd.bfs_pop) head <= head + QW'(1);
        if (hit && int'(tail) < MAX_NODES) tail <= tail + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bfs_init) begin
      reach    <= NN'(1);
      queue[0] <= '0;
    end else if (hit) begin
      reach[i_d]  <= 1'b1;
      parent[i_d] <= v_r;
      if (int'(tail) < MAX_NODES) queue[tail[NW-1:0]] <= i_d;
    end
    if (cmd.bfs_pop) begin
      v_r <= queue[head[NW-1:0]];
      i_r <= '0;
    end else if (cmd.bfs_rd) begin
      i_r <= i_r + NW'(1);
    end
    i_d <= i_r;
  end

  // Augmentation along the parent chain: first the bottleneck, then the update
  always_ff @(posedge clk) begin
    if (cmd.aug_init) begin
      cur  <= sink;
      flow <= '1;
    end else if (cmd.aug_rd || cmd.sub_rd) begin
      par_r <= par_cur;
    end else if (cmd.aug_min) begin
      if (res_rd_a < flow) flow <= res_rd_a;
      cur <= (par_r == '0) ? sink : par_r;
    end else if (cmd.sub_w2) begin
      cur <= par_r;
    end
  end

  // Cut accumulation and ascending selection of edge numbers
  logic [TW-1:0]     cnt;
  logic [MAT_W-1:0]  sum;
  logic [SUM_X-1:0]  sum_ext;
  logic [EW-1:0]     prev;
  logic [EW-1:0]     best;
  logic              found;
  logic [CNT_W-1:0]  e;
  logic [CNT_W-1:0]  tot;
  logic              is_cut;
  logic              cand;
  logic              load_out;

  assign is_cut  = (cap_eff != '0) && reach[k_d[AW-1:NW]] && !reach[k_d[NW-1:0]] &&
                   (int'(k_d[NW-1:0]) < int'(n_reg));
  assign cand    = sel_p && is_cut && (num_rd > prev) && (!found || num_rd < best);
  assign sum_ext = SUM_X'(sum) + SUM_X'(cap_eff);
  assign tot     = (int'(cnt) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : CNT_W'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.cut_init) begin
      cnt   <= '0;
      sum   <= '0;
      prev  <= '0;
      e     <= '0;
      found <= 1'b0;
    end else begin
      if (cut_p && is_cut) begin
        cnt <= cnt + TW'(1);
        sum <= sum_ext[MAT_W] ? MAT_MAX : sum_ext[MAT_W-1:0];
      end
      if (cmd.emit_load) begin
        prev  <= best;
        e     <= e + CNT_W'(1);
        found <= 1'b0;
      end else if (cand) begin
        best  <= num_rd;
        found <= 1'b1;
      end
    end
  end

  // Result register
  assign load_out = cmd.emit_load || cmd.empty_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cut_count   <= tot;
      cut_sum     <= sum;
      edge_valid  <= cmd.emit_load;
      edge_number <= cmd.emit_load ? best : '0;
      last        <= cmd.empty_load || (CNT_W'(e + CNT_W'(1)) == tot);
    end
  end

  assign stat.add_ok    = add_ok;
  assign stat.k_last    = (k == AW'(DEPTH - 1));
  assign stat.i_last    = (i_r == sink);
  assign stat.q_empty   = (head == tail);
  assign stat.sink_hit  = reach[sink];
  assign stat.par_zero  = (par_r == '0);
  assign stat.cut_none  = (cnt == '0);
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.emit_last = (CNT_W'(e + CNT_W'(1)) == tot);

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (head <= tail) && (int'(tail) <= MAX_NODES))
    else $error("search queue head passed tail or tail overflowed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> stat.out_free)
    else $error("result register loaded while a result is still waiting");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && e != '0) |-> (found && best > prev))
    else $error("cut edge numbers not emitted in ascending order");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !edge_valid) |-> (last && cut_count == '0))
    else $error("empty-cut result malformed");

endmodule

// File: src/min_cut_max_flow.sv
// ----------------------------------------------------------------------------
// Min-cut / max-flow engine
// Edge loader plus Edmonds-Karp maximum flow and ordered minimum-cut output.
// ----------------------------------------------------------------------------
// An add request reads the capacity entry, then writes both directions
// (a dropped request or one with a bad endpoint writes nothing); a new
// request is taken once the previous one is finished. A run request
// first copies all D = 2^(2*ceil(log2 MAX_NODES)) capacity entries (256 by
// default) into the residual memory, then repeats a breadth-first search and
// an augmentation along the found path until the sink is cut off. The cut
// sweep reads all D entries, and each emitted cut edge costs one more sweep,
// since edge numbers are picked in ascending order by repeated scans of the
// capacity memory, which has one read port. Results leave through a one-entry
// output register, so a stalled consumer only holds the emission. The edge
// store is cleared when the last result of a run is loaded.
module min_cut_max_flow #(
  parameter int MAX_NODES = mcmf_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = mcmf_pkg::DEF_MAX_EDGES,
  parameter int CAP_WIDTH = mcmf_pkg::DEF_CAP_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            op,
  input  logic [mcmf_pkg::NODE_W-1:0]     from_node,
  input  logic [mcmf_pkg::NODE_W-1:0]     to_node,
  input  logic [CAP_WIDTH-1:0]            edge_capacity,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcmf_pkg::NODE_W-1:0]     node_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcmf_pkg::CNT_W-1:0]      cut_count,
  output logic [mcmf_pkg::MAT_W-1:0]      cut_sum,
  output logic                            edge_valid,
  output logic [$clog2(MAX_EDGES+1)-1:0]  edge_number,
  output logic                            last
);
  import mcmf_pkg::*;

  mcmf_cmd_t  cmd;
  mcmf_stat_t stat;

  assign cfg_ready = 1'b1;

  mcmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mcmf_dpath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .CAP_WIDTH (CAP_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .from_node     (from_node),
    .to_node       (to_node),
    .edge_capacity (edge_capacity),
    .cfg_valid     (cfg_valid),
    .node_count    (node_count),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .cut_count     (cut_count),
    .cut_sum       (cut_sum),
    .edge_valid    (edge_valid),
    .edge_number   (edge_number),
    .last          (last)
  );

endmodule

// File: tb/sv/min_cut_max_flow_tb.sv
// ----------------------------------------------------------------------------
// Min-cut / max-flow engine testbench
// Drives add and run requests at random pace, predicts every cut result with
// an independent Edmonds-Karp model and checks each result field by field.
// ----------------------------------------------------------------------------
module min_cut_max_flow_tb;
  import mcmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = DEF_MAX_NODES;
  localparam int EDGES = DEF_MAX_EDGES;
  localparam int CAP_MAX = (1 << MAT_W) - 1;

  typedef struct {
    logic       op;
    logic [4:0] a;
    logic [4:0] b;
    logic [15:0] c;
  } edge_req_t;

  typedef struct {
    logic [CNT_W-1:0] cnt;
    logic [MAT_W-1:0] sum;
    logic             ev;
    logic [10:0]      num;
    logic             lst;
  } cut_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_ADD;
  logic [4:0] from_node = '0;
  logic [4:0] to_node = '0;
  logic [15:0] edge_capacity = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] node_count = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [CNT_W-1:0] cut_count;
  logic [MAT_W-1:0] cut_sum;
  logic edge_valid;
  logic [10:0] edge_number;
  logic last;

  min_cut_max_flow i_dut (
    .clk, .rst, .in_valid, .in_stall, .op, .from_node, .to_node, .edge_capacity,
    .cfg_valid, .cfg_ready, .node_count, .out_valid, .out_stall, .cut_count,
    .cut_sum, .edge_valid, .edge_number, .last
  );

  edge_req_t pending_q[$];
  cut_res_t  cut_results_q[$];
  bit failed = 0;
  bit calm = 0;
  bit req_taken = 0;
  int cfg_writes = 0;
  int hold_asks = 0;

  // Shadow of the engine state.
  int unsigned cap_mat[NODES][NODES];
  int unsigned num_mat[NODES][NODES];
  longint resid[NODES][NODES];
  int unsigned par[NODES];
  bit reach[NODES];
  int unsigned edge_total = 0;
  int unsigned graph_nodes = NODE_RESET;

  initial forever #10 clk = ~clk;

  function automatic int unsigned sat_sum(longint x);
    return (x > CAP_MAX) ? CAP_MAX : int'(x);
  endfunction

  function automatic bit sink_reachable(int n);
    int q[$];
    int v;
    reach = '{default: 0};
    reach[0] = 1;
    par[0] = 0;
    q.insert(q.size(), 0);
    while (q.size() > 0 && !reach[n-1]) begin
      v = q.pop_front();
      for (int i = 0; i < n; i++) begin
        if (resid[v][i] > 0 && !reach[i]) begin
          reach[i] = 1;
          par[i] = v;
          q.insert(q.size(), i);
        end
      end
    end
    return reach[n-1];
  endfunction

  function automatic void predict_request(edge_req_t r);
    int n;
    longint flow, total;
    int unsigned nums[$];
    int emit;
    cut_res_t e;
    n = graph_nodes;
    if (r.op == OP_ADD) begin
      if (edge_total >= EDGES) return;
      edge_total++;
      if (r.a < 1 || r.a > n || r.b < 1 || r.b > n) return;
      cap_mat[r.a-1][r.b-1] = sat_sum(longint'(cap_mat[r.a-1][r.b-1]) + r.c);
      cap_mat[r.b-1][r.a-1] = sat_sum(longint'(cap_mat[r.b-1][r.a-1]) + r.c);
      num_mat[r.a-1][r.b-1] = edge_total;
      num_mat[r.b-1][r.a-1] = edge_total;
      return;
    end
    for (int v = 0; v < NODES; v++)
      for (int u = 0; u < NODES; u++) resid[v][u] = cap_mat[v][u];
    while (sink_reachable(n)) begin
      flow = 64'h7fff_ffff_ffff;
      for (int i = n - 1; i != 0; i = par[i])
        if (resid[par[i]][i] < flow) flow = resid[par[i]][i];
      for (int i = n - 1; i != 0; i = par[i]) begin
        resid[par[i]][i] -= flow;
        resid[i][par[i]] += flow;
      end
    end
    total = 0;
    for (int v = 0; v < n; v++)
      for (int u = 0; u < n; u++)
        if (cap_mat[v][u] != 0 && reach[v] && !reach[u]) begin
          total += cap_mat[v][u];
          nums.insert(nums.size(), num_mat[v][u]);
        end
    nums.sort();
    while (nums.size() > MAX_RESULTS) void'(nums.pop_back());
    emit = (nums.size() == 0) ? 1 : nums.size();
    for (int k = 0; k < emit; k++) begin
      e.cnt = CNT_W'(nums.size());
      e.sum = MAT_W'(sat_sum(total));
      e.ev  = nums.size() != 0;
      e.num = (nums.size() != 0) ? 11'(nums[k]) : 11'd0;
      e.lst = (k + 1 == emit);
      cut_results_q.insert(cut_results_q.size(), e);
    end
    cap_mat = '{default: 0};
    edge_total = 0;
  endfunction

  // Sampling, prediction and checking at the rising edge.
  always @(posedge clk) begin : watch_ports
    cut_res_t e;
    req_taken = !rst && in_valid && !in_stall;
    if (!rst && cfg_valid && cfg_ready) begin
      graph_nodes = (node_count < 2) ? 2 : (node_count > NODES) ? NODES : node_count;
      cfg_writes <= cfg_writes + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (cut_results_q.size() == 0) begin
        $error("cut result with none expected");
        failed = 1;
      end else begin
        e = cut_results_q.pop_front();
        if (cut_count !== e.cnt) begin
          $error("cut_count expected %0d got %0d", e.cnt, cut_count); failed = 1;
        end
        if (cut_sum !== e.sum) begin
          $error("cut_sum expected %0d got %0d", e.sum, cut_sum); failed = 1;
        end
        if (edge_valid !== e.ev) begin
          $error("edge_valid expected %0d got %0d", e.ev, edge_valid); failed = 1;
        end
        if (edge_number !== e.num) begin
          $error("edge_number expected %0d got %0d", e.num, edge_number); failed = 1;
        end
        if (last !== e.lst) begin
          $error("last expected %0d got %0d", e.lst, last); failed = 1;
        end
      end
    end
    if (req_taken) predict_request('{op, from_node, to_node, edge_capacity});
  end

  always @(negedge clk) begin : drive_requests
    edge_req_t r;
    if (!rst && (!in_valid || req_taken)) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
        r = pending_q.pop_front();
        op <= r.op;
        from_node <= r.a;
        to_node <= r.b;
        edge_capacity <= r.c;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall, with an occasional long hold-off on request.
  always @(negedge clk) begin : drive_stall
    static int hold_left = 0;
    static int holds_seen = 0;
    if (holds_seen != hold_asks) begin
      holds_seen = hold_asks;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  task automatic push_req(logic o, logic [4:0] a, logic [4:0] b, logic [15:0] c);
    pending_q.insert(pending_q.size(), '{o, a, b, c});
  endtask

  task automatic drain;
    wait (pending_q.size() == 0 && !in_valid && cut_results_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_nodes(logic [4:0] v);
    int seen;
    drain();
    seen = cfg_writes;
    @(negedge clk);
    node_count <= v;
    cfg_valid <= 1'b1;
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_graphs(int groups, int max_nodes);
    int n;
    for (int g = 0; g < groups; g++) begin
      n = (graph_nodes < max_nodes) ? graph_nodes : max_nodes;
      repeat ($urandom_range(12, 1)) begin
        if ($urandom_range(99) < 10)
          push_req(OP_ADD, 5'($urandom_range(31)), 5'($urandom_range(31)), 16'($urandom));
        else
          push_req(OP_ADD, 5'($urandom_range(n, 1)), 5'($urandom_range(n, 1)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)));
      end
      push_req(OP_RUN, 5'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, self loop, bad endpoints, parallel edges, empty cut.
    push_req(OP_RUN, 5'd31, 5'd0, 16'hffff);
    push_req(OP_ADD, 5'd1, 5'd16, 16'hffff);
    push_req(OP_ADD, 5'd16, 5'd1, 16'd0);
    push_req(OP_ADD, 5'd5, 5'd5, 16'hffff);
    push_req(OP_ADD, 5'd0, 5'd3, 16'd9);
    push_req(OP_ADD, 5'd17, 5'd2, 16'd9);
    push_req(OP_ADD, 5'd31, 5'd31, 16'd9);
    push_req(OP_ADD, 5'd1, 5'd2, 16'd3);
    push_req(OP_ADD, 5'd2, 5'd16, 16'd5);
    push_req(OP_ADD, 5'd1, 5'd3, 16'd4);
    push_req(OP_ADD, 5'd3, 5'd16, 16'd1);
    push_req(OP_RUN, 5'd0, 5'd0, 16'd0);
    push_req(OP_ADD, 5'd2, 5'd3, 16'd0);
    push_req(OP_RUN, 5'd10, 5'd21, 16'h5a5a);

    // Register clamping both ways, then parallel edges on two nodes.
    write_nodes(5'd0);
    push_req(OP_ADD, 5'd1, 5'd2, 16'd1);
    push_req(OP_RUN, 5'd0, 5'd0, 16'd0);
    write_nodes(5'd31);
    random_graphs(2, NODES);
    write_nodes(5'd1);
    repeat (3) push_req(OP_ADD, 5'd0, 5'd2, 16'd1);
    push_req(OP_ADD, 5'd1, 5'd2, 16'd5);
    push_req(OP_ADD, 5'd1, 5'd2, 16'd7);
    push_req(OP_RUN, 5'd0, 5'd0, 16'd0);

    // Results held back long enough that the engine stops taking requests.
    write_nodes(5'd8);
    hold_asks++;
    random_graphs(4, 8);

    write_nodes(5'd17);
    calm = 1;
    random_graphs(5, NODES);
    drain();
    calm = 0;

    for (int p = 0; p < 8; p++) begin
      write_nodes((p % 3 == 0) ? 5'd16 : (p % 3 == 1) ? 5'd2 : 5'($urandom_range(9, 3)));
      random_graphs(6, NODES);
    end

    drain();
    repeat (100) @(posedge clk);
    if (!failed && cut_results_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

endmodule
